>>> rtl/core/link_serialization_delay_defines.svh
// Assertion macros shared by the link serialisation delay RTL.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef LINK_SERIALIZATION_DELAY_DEFINES_SVH
`define LINK_SERIALIZATION_DELAY_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsd: property violated");

// Check that cons holds a fixed number of cycles after ante.
`define LSD_ASSERT_DLY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("lsd: property violated after delay");

`endif

>>> rtl/core/lsd_pkg.sv
// Package for the link serialisation delay block: widths, constants, status
// codes and the beat types that travel down the cell chains. No dependencies.
package lsd_pkg;

  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;

  localparam logic [DATA_W-1:0] MAX_VAL         = '1;
  localparam logic [DATA_W-1:0] NS_PER_BYTE_SEC = 64'd8000000000;

  // Bits that the scale factor really occupies
  localparam int MUL_W = $clog2(NS_PER_BYTE_SEC + 1);

  // Largest whole-seconds quotient whose scaled value still fits
  localparam logic [DATA_W-1:0] WHOLE_MAX = MAX_VAL / NS_PER_BYTE_SEC;
  localparam int WHOLE_W = $clog2(WHOLE_MAX + 1);
  localparam int PROD_W  = WHOLE_W + MUL_W;

  localparam int DIV_CELLS = DATA_W;
  localparam int MDV_CELLS = MUL_W;
  // Division chain, scale stage, mul-div chain, finishing stage
  localparam int LATENCY   = DIV_CELLS + 1 + MDV_CELLS + 1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

  // Beat in the whole-seconds division chain. acc holds the dividend bits
  // still to be consumed at the top and the quotient bits gathered at the bottom.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] rem;
  } div_beat_t;

  // Beat in the fractional mul-div chain
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              ovf;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] rem;
    logic [MUL_W-1:0]  quo;
    logic [DATA_W-1:0] ns;
  } mdv_beat_t;

endpackage

>>> rtl/core/lsd_div_cell.sv
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
// Depends on lsd_pkg and link_serialization_delay_defines.svh.
`include "link_serialization_delay_defines.svh"

module lsd_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  lsd_pkg::div_beat_t in_beat,
  output lsd_pkg::div_beat_t out_beat
);
  import lsd_pkg::*;

  logic [DATA_W:0]   cand;
  logic              fits;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] acc_next;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    cand     = {in_beat.rem, in_beat.acc[DATA_W-1]};
    fits     = (cand >= {1'b0, in_beat.den});
    rem_next = fits ? DATA_W'(cand - {1'b0, in_beat.den}) : cand[DATA_W-1:0];
    acc_next = {in_beat.acc[DATA_W-2:0], fits};
  end

  // Advance the valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    out_beat.zero <= in_beat.zero;
    out_beat.den  <= in_beat.den;
    out_beat.acc  <= acc_next;
    out_beat.rem  <= rem_next;
  end

  // Partial remainder always stays below the divisor
  `LSD_ASSERT_IMP(a_div_rem_below_den, clk, rst,
    out_beat.valid && !out_beat.zero, out_beat.rem < out_beat.den)

endmodule

>>> rtl/core/lsd_scale.sv
// Scale stage: checks the whole-seconds quotient for overflow and scales it
// to nanoseconds. Depends on lsd_pkg.
module lsd_scale (
  input  logic              clk,
  input  logic              rst,
  input  lsd_pkg::div_beat_t in_beat,
  output lsd_pkg::mdv_beat_t out_beat
);
  import lsd_pkg::*;

  logic              whole_ovf;
  logic [PROD_W-1:0] prod;

  // Scale only the bits that can survive the overflow check
  always_comb begin
    whole_ovf = (in_beat.acc > WHOLE_MAX);
    prod      = PROD_W'(in_beat.acc[WHOLE_W-1:0]) * PROD_W'(NS_PER_BYTE_SEC[MUL_W-1:0]);
  end

  // Hold the valid mark across the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
  end

  // Load the mul-div chain with the remainder as numerator
  always_ff @(posedge clk) begin
    out_beat.zero <= in_beat.zero;
    out_beat.ovf  <= whole_ovf;
    out_beat.den  <= in_beat.den;
    out_beat.num  <= in_beat.rem;
    out_beat.rem  <= '0;
    out_beat.quo  <= '0;
    out_beat.ns   <= prod[DATA_W-1:0];
  end

endmodule

>>> rtl/core/lsd_mdv_cell.sv
// One shift-add mul-div cell: handles one bit of the scale factor, keeping
// quotient and remainder modulo the divisor. Depends on lsd_pkg and the defines.
`include "link_serialization_delay_defines.svh"

module lsd_mdv_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              mul_bit,
  input  lsd_pkg::mdv_beat_t in_beat,
  output lsd_pkg::mdv_beat_t out_beat
);
  import lsd_pkg::*;

  logic [DATA_W-1:0] gap;
  logic [DATA_W-1:0] room;
  logic [DATA_W-1:0] rem_dbl;
  logic [MUL_W-1:0]  quo_dbl;
  logic [DATA_W-1:0] rem_next;
  logic [MUL_W-1:0]  quo_next;

  // Double the running value, then add the numerator if this bit is set
  always_comb begin
    gap  = in_beat.den - in_beat.rem;
    room = in_beat.den - in_beat.num;
    if (in_beat.rem >= gap) begin
      rem_dbl = in_beat.rem - gap;
      quo_dbl = {in_beat.quo[MUL_W-2:0], 1'b1};
    end else begin
      rem_dbl = {in_beat.rem[DATA_W-2:0], 1'b0};
      quo_dbl = {in_beat.quo[MUL_W-2:0], 1'b0};
    end
    rem_next = rem_dbl;
    quo_next = quo_dbl;
    if (mul_bit) begin
      if (rem_dbl >= room) begin
        rem_next = rem_dbl - room;
        quo_next = quo_dbl + MUL_W'(1);
      end else begin
        rem_next = rem_dbl + in_beat.num;
      end
    end
  end

  // Advance the valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    out_beat.zero <= in_beat.zero;
    out_beat.ovf  <= in_beat.ovf;
    out_beat.den  <= in_beat.den;
    out_beat.num  <= in_beat.num;
    out_beat.rem  <= rem_next;
    out_beat.quo  <= quo_next;
    out_beat.ns   <= in_beat.ns;
  end

  // Running remainder always stays below the divisor
  `LSD_ASSERT_IMP(a_mdv_rem_below_den, clk, rst,
    out_beat.valid && !out_beat.zero, out_beat.rem < out_beat.den)

endmodule

>>> rtl/core/link_serialization_delay.sv
// Top level of the link serialisation delay block: ceil(bytes * 8e9 / bandwidth).
// Depends on lsd_pkg, lsd_div_cell, lsd_scale, lsd_mdv_cell and the defines.
//
//   channel   handshake         payload
//   input     start / busy      pkt_bytes, link_rate
//   result    done (strobe)     delay_ns, status
//
// A new beat may be started in every cycle; busy is high only during reset.
// Each result passes through 64 division cells, one scale stage, 33 mul-div
// cells (one per bit of the scale factor) and one finishing stage. Reset
// empties the chain; beats in flight are dropped.
// Results are shown on done for one cycle and cannot be held off.
`include "link_serialization_delay_defines.svh"

module link_serialization_delay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lsd_pkg::DATA_W-1:0]    pkt_bytes,
  input  logic [lsd_pkg::DATA_W-1:0]    link_rate,
  output logic                          done,
  output logic [lsd_pkg::DATA_W-1:0]    delay_ns,
  output logic [lsd_pkg::STATUS_W-1:0]  status
);
  import lsd_pkg::*;

  div_beat_t         div_pipe [DIV_CELLS+1];
  mdv_beat_t         mdv_pipe [MDV_CELLS+1];
  mdv_beat_t         last_beat;
  logic [DATA_W+1:0] total;
  logic              sum_ovf;

  assign busy = rst;

  // Form the entry beat
  always_comb begin
    div_pipe[0].valid = start && !busy;
    div_pipe[0].zero  = (pkt_bytes == '0) || (link_rate == '0);
    div_pipe[0].den   = link_rate;
    div_pipe[0].acc   = pkt_bytes;
    div_pipe[0].rem   = '0;
  end

  // Whole seconds: one quotient bit per cell
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    lsd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_beat  (div_pipe[k]),
      .out_beat (div_pipe[k+1])
    );
  end

  lsd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (div_pipe[DIV_CELLS]),
    .out_beat (mdv_pipe[0])
  );

  // Fraction: one scale-factor bit per cell, most significant first
  for (genvar k = 0; k < MDV_CELLS; k++) begin : g_mdv
    lsd_mdv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .mul_bit  (NS_PER_BYTE_SEC[MUL_W-1-k]),
      .in_beat  (mdv_pipe[k]),
      .out_beat (mdv_pipe[k+1])
    );
  end

  // Add fraction and round-up bit; a carry out of the data width is overflow
  always_comb begin
    last_beat = mdv_pipe[MDV_CELLS];
    total     = (DATA_W+2)'(last_beat.ns) + (DATA_W+2)'(last_beat.quo)
              + (DATA_W+2)'(last_beat.rem != '0);
    sum_ovf   = last_beat.ovf || (total[DATA_W+1:DATA_W] != 2'b00);
  end

  // Strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last_beat.valid;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    priority if (last_beat.zero) begin
      status   <= ST_ZERO;
      delay_ns <= '0;
    end else if (sum_ovf) begin
      status   <= ST_OVF;
      delay_ns <= '0;
    end else begin
      status   <= ST_OK;
      delay_ns <= total[DATA_W-1:0];
    end
  end

  // Every started beat comes out after a fixed latency, and nothing else does
  `LSD_ASSERT_DLY(a_start_gives_done, clk, rst, start && !busy, LATENCY, done)
  `LSD_ASSERT_IMP(a_done_has_start, clk, rst, done, $past(start && !busy, LATENCY))
  // Delay is zero whenever a fault is flagged
  `LSD_ASSERT_IMP(a_fault_zero_delay, clk, rst, done && (status != ST_OK), delay_ns == '0)

endmodule
